// ===== hdl/kvi_pkg.sv =====
// kvi_pkg: shared codes, entry layout and controller/datapath interface types
// for the keyframe vector interpolator. No dependencies.
package kvi_pkg;

	// command field codes; a query is any code with bit 1 set
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam int         CMD_QUERY_BIT = 1;

	// one key table entry: {z, y, x, time}
	localparam int ENTRY_W = 128;
	localparam int DIV_STEPS = 16;

	typedef enum logic [2:0] {
		ST_INTERP      = 3'd0,
		ST_SINGLE      = 3'd1,
		ST_CLAMP_FIRST = 3'd2,
		ST_CLAMP_LAST  = 3'd3,
		ST_EMPTY       = 3'd4,
		ST_LOADED      = 3'd5,
		ST_FULL        = 3'd6,
		ST_CLEARED     = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_KEY,
		SEL_RES
	} out_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic     capture;
		logic     clear_count;
		logic     append;
		logic     rd_en;
		logic     idx_inc;
		logic     save_prev;
		logic     div_init;
		logic     div_step;
		logic     mul;
		logic     acc;
		logic [1:0] comp;
		logic     out_load;
		out_sel_t out_sel;
		status_t  out_status;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] command;
		logic       count_zero;
		logic       count_one;
		logic       full;
		logic       t_lt_cur;
		logic       idx_last;
	} dp_stat_t;

endpackage

// ===== hdl/keyframe_vector_interpolator_core.sv =====
// Keyframe vector interpolator, top level. Clear and append pass decode and the
// finish state from accept to result; a query does a search that walks n keys
// (each key through a registered table read and a check), plus 16 divide
// steps and three multiply/add pairs. One item is in work at a time; the next is
// accepted once the result sits in the output register. Reset (arst_n, async,
// low) empties the key table by zeroing the fill count and drops any result.
// Uses kvi_pkg, kvi_ctrl, kvi_dp, kvi_ram.
module keyframe_vector_interpolator_core
	import kvi_pkg::*;
#(
	parameter int KEY_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	// input item channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [31:0]        key_time,
	input  logic signed [31:0] key_x,
	input  logic signed [31:0] key_y,
	input  logic signed [31:0] key_z,
	input  logic [31:0]        query_time,
	// result item channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [2:0]         status
);

	// Controller and datapath talk only through these two groups.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer: decode, key scan, divide, per-component multiply, hand-off.
	kvi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	// Key table RAM, divider, shared multiplier and the output register.
	kvi_dp #(
		.KEY_DEPTH(KEY_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.command   (command),
		.key_time  (key_time),
		.key_x     (key_x),
		.key_y     (key_y),
		.key_z     (key_z),
		.query_time(query_time),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.status    (status)
	);

endmodule

// ===== hdl/kvi_ram.sv =====
// kvi_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module kvi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/kvi_dp.sv =====
// kvi_dp: key table, scan index, restoring divider, shared multiplier and
// result registers. Uses kvi_pkg and kvi_ram.
module kvi_dp
	import kvi_pkg::*;
#(
	parameter int KEY_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [1:0]          command,
	input  logic [31:0]         key_time,
	input  logic signed [31:0]  key_x,
	input  logic signed [31:0]  key_y,
	input  logic signed [31:0]  key_z,
	input  logic [31:0]         query_time,
	output logic signed [31:0]  out_x,
	output logic signed [31:0]  out_y,
	output logic signed [31:0]  out_z,
	output logic [2:0]          status
);

	localparam int IDX_W = $clog2(KEY_DEPTH);
	localparam int CNT_W = $clog2(KEY_DEPTH + 1);

	logic [1:0]         command_q;
	logic [31:0]        key_time_q, key_x_q, key_y_q, key_z_q, query_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic [ENTRY_W-1:0] rdata, prev_q;
	logic [31:0]        rem_q, dvs_q;
	logic [15:0]        quo_q;
	logic signed [49:0] prod_q;
	logic [31:0]        res_q [3];
	logic [31:0]        ox_q, oy_q, oz_q;
	logic [2:0]         ostat_q;

	// table, addressed by fill count for writes and scan index for reads
	kvi_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(KEY_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.append),
		.waddr(count_q[IDX_W-1:0]),
		.wdata({key_z_q, key_y_q, key_x_q, key_time_q}),
		.re   (cmd.rd_en),
		.raddr(idx_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear_count) begin
			count_q <= '0;
		end else if (cmd.append) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.capture) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			command_q  <= command;
			key_time_q <= key_time;
			key_x_q    <= key_x;
			key_y_q    <= key_y;
			key_z_q    <= key_z;
			query_q    <= query_time;
		end
		if (cmd.save_prev) begin
			prev_q <= rdata;
		end
	end

	// restoring divide: factor = ((t - t_i) << 16) / (t_i+1 - t_i), num < dt
	logic [32:0] rem2;
	assign rem2 = {rem_q, 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= query_q - prev_q[31:0];
			dvs_q <= rdata[31:0] - prev_q[31:0];
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem2 >= {1'b0, dvs_q}) begin
				rem_q <= 32'(rem2 - {1'b0, dvs_q});
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= rem2[31:0];
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	// component select for the shared multiplier
	logic [31:0] s_comp, e_comp;
	always_comb begin
		unique case (cmd.comp)
			2'd1: begin
				s_comp = prev_q[95:64];
				e_comp = rdata[95:64];
			end
			2'd2: begin
				s_comp = prev_q[127:96];
				e_comp = rdata[127:96];
			end
			default: begin
				s_comp = prev_q[63:32];
				e_comp = rdata[63:32];
			end
		endcase
	end

	logic signed [32:0] delta;
	logic signed [16:0] fac;
	logic signed [49:0] prod_d, prod_sh;
	assign delta   = $signed({e_comp[31], e_comp}) - $signed({s_comp[31], s_comp});
	assign fac     = $signed({1'b0, quo_q});
	assign prod_d  = fac * delta;
	assign prod_sh = prod_q >>> 16;   // floor toward minus infinity

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= prod_d;
		end
		if (cmd.acc) begin
			res_q[cmd.comp] <= s_comp + prod_sh[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ostat_q <= cmd.out_status;
			unique case (cmd.out_sel)
				SEL_KEY: begin
					ox_q <= rdata[63:32];
					oy_q <= rdata[95:64];
					oz_q <= rdata[127:96];
				end
				SEL_RES: begin
					ox_q <= res_q[0];
					oy_q <= res_q[1];
					oz_q <= res_q[2];
				end
				default: begin
					ox_q <= '0;
					oy_q <= '0;
					oz_q <= '0;
				end
			endcase
		end
	end

	assign out_x  = ox_q;
	assign out_y  = oy_q;
	assign out_z  = oz_q;
	assign status = ostat_q;

	always_comb begin
		stat.command    = command_q;
		stat.count_zero = (count_q == '0);
		stat.count_one  = (count_q == CNT_W'(1));
		stat.full       = (count_q == CNT_W'(KEY_DEPTH));
		stat.t_lt_cur   = (query_q < rdata[31:0]);
		stat.idx_last   = (CNT_W'(idx_q) == CNT_W'(count_q - 1'b1));
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(KEY_DEPTH))
		else $error("key count beyond table depth");

	a_append_inc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |=> count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("append did not advance key count");

endmodule

// ===== hdl/kvi_ctrl.sv =====
// kvi_ctrl: controller state machine sequencing decode, table scan, divide,
// multiply and result hand-off. Uses kvi_pkg.
module kvi_ctrl
	import kvi_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_FIRST,
		S_READ,
		S_CHECK,
		S_DIV,
		S_MUL,
		S_ACC,
		S_FINISH
	} state_t;

	state_t   state_q;
	logic     out_valid_q;
	status_t  fin_status_q;
	out_sel_t fin_sel_q;
	logic [1:0] comp_q;
	logic [3:0] step_q;

	logic is_query;
	logic out_free;
	assign is_query = stat.command[CMD_QUERY_BIT];
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd = '0;
		cmd.comp       = comp_q;
		cmd.out_sel    = fin_sel_q;
		cmd.out_status = fin_status_q;
		unique case (state_q)
			S_IDLE:   cmd.capture = in_valid;
			S_DECODE: begin
				if (is_query) begin
					cmd.rd_en = !stat.count_zero;
				end else if (stat.command == CMD_APPEND) begin
					cmd.append = !stat.full;
				end else begin
					cmd.clear_count = 1'b1;
				end
			end
			S_FIRST: begin
				if (!stat.count_one && !stat.t_lt_cur) begin
					cmd.save_prev = 1'b1;
					cmd.idx_inc   = 1'b1;
				end
			end
			S_READ:   cmd.rd_en = 1'b1;
			S_CHECK: begin
				if (stat.t_lt_cur) begin
					cmd.div_init = 1'b1;
				end else if (!stat.idx_last) begin
					cmd.save_prev = 1'b1;
					cmd.idx_inc   = 1'b1;
				end
			end
			S_DIV:    cmd.div_step = 1'b1;
			S_MUL:    cmd.mul = 1'b1;
			S_ACC:    cmd.acc = 1'b1;
			S_FINISH: cmd.out_load = out_free;
			default:  cmd = '0;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			fin_status_q <= ST_EMPTY;
			fin_sel_q    <= SEL_ZERO;
			comp_q       <= '0;
			step_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					fin_sel_q <= SEL_ZERO;
					if (is_query) begin
						if (stat.count_zero) begin
							fin_status_q <= ST_EMPTY;
							state_q      <= S_FINISH;
						end else begin
							state_q <= S_FIRST;
						end
					end else if (stat.command == CMD_APPEND) begin
						fin_status_q <= stat.full ? ST_FULL : ST_LOADED;
						state_q      <= S_FINISH;
					end else begin
						fin_status_q <= ST_CLEARED;
						state_q      <= S_FINISH;
					end
				end
				S_FIRST: begin
					if (stat.count_one) begin
						fin_status_q <= ST_SINGLE;
						fin_sel_q    <= SEL_KEY;
						state_q      <= S_FINISH;
					end else if (stat.t_lt_cur) begin
						fin_status_q <= ST_CLAMP_FIRST;
						fin_sel_q    <= SEL_KEY;
						state_q      <= S_FINISH;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (stat.t_lt_cur) begin
						step_q  <= '0;
						state_q <= S_DIV;
					end else if (stat.idx_last) begin
						fin_status_q <= ST_CLAMP_LAST;
						fin_sel_q    <= SEL_KEY;
						state_q      <= S_FINISH;
					end else begin
						state_q <= S_READ;
					end
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == 4'(DIV_STEPS - 1)) begin
						comp_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (comp_q == 2'd2) begin
						fin_status_q <= ST_INTERP;
						fin_sel_q    <= SEL_RES;
						state_q      <= S_FINISH;
					end else begin
						comp_q  <= comp_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result overwritten while stalled");

	a_mul_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> ($past(state_q) == S_DIV || $past(state_q) == S_ACC))
		else $error("multiply entered out of sequence");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DECODE))
		else $error("accepted item not decoded");

endmodule

// ===== verif/tb.sv =====
// tb: self-checking bench for keyframe_vector_interpolator_core. A directed table,
// then random key sets and queries, checked against expectations written into the
// directed rows or an in-bench key table model. Depends on kvi_pkg and the core RTL.
module tb;
	import kvi_pkg::*;

	localparam int KEY_DEPTH = 64;
	localparam logic [1:0] CMD_QUERY     = 2'd2;
	localparam logic [1:0] CMD_QUERY_ALT = 2'd3;	// bit 0 is ignored, still a query
	localparam int RAND_ITEMS   = 400;
	localparam int MAX_REPORTS  = 10;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 200;	// longest query walks all KEY_DEPTH keys

	typedef struct {
		logic [1:0]         cmd;
		logic [31:0]        ktime;
		logic signed [31:0] kx, ky, kz;
		logic [31:0]        qtime;
	} key_item_t;

	typedef struct {
		logic signed [31:0] x, y, z;
		status_t            st;
	} vec_result_t;

	typedef struct {
		key_item_t   item;
		bit          typed;	// expected result written into the row
		vec_result_t res;
	} dir_row_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic [1:0]         command    = '0;
	logic [31:0]        key_time   = '0;
	logic signed [31:0] key_x      = '0;
	logic signed [31:0] key_y      = '0;
	logic signed [31:0] key_z      = '0;
	logic [31:0]        query_time = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic signed [31:0] out_x, out_y, out_z;
	logic [2:0]         status;

	keyframe_vector_interpolator_core #(.KEY_DEPTH(KEY_DEPTH)) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.key_time   (key_time),
		.key_x      (key_x),
		.key_y      (key_y),
		.key_z      (key_z),
		.query_time (query_time),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.status     (status)
	);

	always #5 clk = ~clk;

	// bench copy of the key table
	logic [31:0]        tbl_time [KEY_DEPTH];
	logic signed [31:0] tbl_x    [KEY_DEPTH];
	logic signed [31:0] tbl_y    [KEY_DEPTH];
	logic signed [31:0] tbl_z    [KEY_DEPTH];
	int                 tbl_count = 0;

	vec_result_t pending_vecs[$];
	dir_row_t    dir_rows[$];
	int          err_count       = 0;
	int          items_sent      = 0;
	int          results_checked = 0;
	int          status_hits[8]  = '{default: 0};
	int          burst_left      = 0;

	// start + floor(factor * (end - start) / 2^16); factor is Q0.16
	function automatic logic signed [31:0] blend(logic signed [31:0] a,
		logic signed [31:0] b, longint f);
		longint span;
		longint prod;
		span = longint'(b) - longint'(a);
		prod = f * span;
		return 32'(longint'(a) + (prod >>> 16));
	endfunction

	// applies one item to the table and returns the result it should give
	function automatic vec_result_t key_table_step(key_item_t it);
		vec_result_t r;
		int          hit;
		int          seg;
		logic [63:0] num;
		logic [63:0] dt;
		logic [63:0] f;
		r.x = '0;
		r.y = '0;
		r.z = '0;
		hit = -1;
		seg = -1;
		if (it.cmd[CMD_QUERY_BIT]) begin
			if (tbl_count == 0) begin
				r.st = ST_EMPTY;
			end else if (tbl_count == 1) begin
				hit = 0;
				r.st = ST_SINGLE;
			end else if (it.qtime < tbl_time[0]) begin
				hit = 0;
				r.st = ST_CLAMP_FIRST;
			end else begin
				// first segment whose upper key time lies beyond the query
				for (int i = 0; i + 1 < tbl_count; i++) begin
					if (seg < 0 && it.qtime < tbl_time[i + 1])
						seg = i;
				end
				if (seg >= 0) begin
					num = {32'b0, it.qtime - tbl_time[seg]};
					dt = {32'b0, tbl_time[seg + 1] - tbl_time[seg]};
					f = (num << 16) / dt;
					r.x = blend(tbl_x[seg], tbl_x[seg + 1], longint'(f));
					r.y = blend(tbl_y[seg], tbl_y[seg + 1], longint'(f));
					r.z = blend(tbl_z[seg], tbl_z[seg + 1], longint'(f));
					r.st = ST_INTERP;
				end else begin
					hit = tbl_count - 1;
					r.st = ST_CLAMP_LAST;
				end
			end
			if (hit >= 0) begin
				r.x = tbl_x[hit];
				r.y = tbl_y[hit];
				r.z = tbl_z[hit];
			end
		end else if (it.cmd == CMD_APPEND) begin
			if (tbl_count >= KEY_DEPTH) begin
				r.st = ST_FULL;
			end else begin
				tbl_time[tbl_count] = it.ktime;
				tbl_x[tbl_count] = it.kx;
				tbl_y[tbl_count] = it.ky;
				tbl_z[tbl_count] = it.kz;
				tbl_count++;
				r.st = ST_LOADED;
			end
		end else begin
			tbl_count = 0;
			r.st = ST_CLEARED;
		end
		return r;
	endfunction

	task automatic add_row(input logic [1:0] cmd, input logic [31:0] kt,
		input logic [31:0] kx, input logic [31:0] ky, input logic [31:0] kz,
		input logic [31:0] qt, input bit typed, input logic [31:0] ex,
		input logic [31:0] ey, input logic [31:0] ez, input status_t est);
		dir_row_t row;
		row.item = '{cmd, kt, kx, ky, kz, qt};
		row.typed = typed;
		row.res = '{ex, ey, ez, est};
		dir_rows.push_back(row);
	endtask

	// offers one item, idling between bursts; predicts once it is taken
	task automatic send_item(input key_item_t it, input bit typed,
		input vec_result_t typed_res);
		vec_result_t predicted;
		int          gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_valid   <= 1'b1;
		command    <= it.cmd;
		key_time   <= it.ktime;
		key_x      <= it.kx;
		key_y      <= it.ky;
		key_z      <= it.kz;
		query_time <= it.qtime;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = key_table_step(it);
		pending_vecs.push_back(typed ? typed_res : predicted);
		items_sent++;
		burst_left--;
	endtask

	// sender goes quiet until every expected result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_vecs.size() != 0);
	endtask

	function automatic logic [31:0] pick_query_time();
		int n;
		int k;
		n = tbl_count;
		if (n == 0)
			return $urandom;
		k = $urandom_range(0, n - 1);
		case ($urandom_range(0, 9))
			0, 1:          return $urandom;
			2, 3, 4, 5:    return $urandom_range(tbl_time[0], tbl_time[n - 1]);
			6, 7:          return tbl_time[k];
			8:             return tbl_time[k] - 32'd1;
			default:       return tbl_time[k] + 32'd1;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_comp();
		if ($urandom_range(0, 1))
			return $urandom;
		return 32'($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
	endfunction

	// result checker
	always @(posedge clk) begin
		vec_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			status_hits[status]++;
			if (pending_vecs.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("ERROR: unexpected result x=%h y=%h z=%h status=%0d",
						out_x, out_y, out_z, status);
			end else begin
				want = pending_vecs.pop_front();
				if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
					status !== want.st) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("ERROR: result %0d exp x=%h y=%h z=%h st=%0d, got x=%h y=%h z=%h st=%0d",
							results_checked, want.x, want.y, want.z, want.st,
							out_x, out_y, out_z, status);
				end
			end
		end
	end

	// receiver: stall pattern in modes, with a long hold-off now and then
	initial begin
		int pct;
		int mode_left;
		int run_len;
		pct = 0;
		mode_left = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			run_len = $urandom_range(1500, 5000);
			repeat (run_len) begin
				if (mode_left == 0) begin
					case ($urandom_range(0, 4))
						0, 1:    pct = 0;
						2:       pct = 25;
						3:       pct = 60;
						default: pct = 90;
					endcase
					mode_left = $urandom_range(32, 256);
				end
				mode_left--;
				out_stall <= ($urandom_range(0, 99) < pct);
				@(posedge clk);
			end
			// core holds its one result and stalls the sender meanwhile
			out_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
		end
	end

	initial begin
		#15_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// stimulus
	initial begin
		key_item_t   it;
		vec_result_t none;
		int          rand_start;
		int          seq;
		int          n_keys;
		int          n_q;
		logic [31:0] step_max;
		logic [31:0] t;

		none = '{32'sd0, 32'sd0, 32'sd0, ST_INTERP};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cmd, key time, x, y, z, query time, typed, expected x, y, z, status
		add_row(CMD_QUERY, 0, 0, 0, 0, 0, 1, 0, 0, 0, ST_EMPTY);
		add_row(CMD_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0, 0, ST_CLEARED);
		add_row(CMD_APPEND, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
			1, 0, 0, 0, ST_LOADED);
		// one key: held for any time
		add_row(CMD_QUERY, 0, 0, 0, 0, 32'h0,
			1, 32'h7FFF_FFFF, 32'h8000_0000, 0, ST_SINGLE);
		add_row(CMD_QUERY, 0, 0, 0, 0, 32'hFFFF_FFFF,
			1, 32'h7FFF_FFFF, 32'h8000_0000, 0, ST_SINGLE);
		add_row(CMD_APPEND, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0,
			1, 0, 0, 0, ST_LOADED);
		add_row(CMD_QUERY, 0, 0, 0, 0, 32'h0000_8000,
			1, 32'h7FFF_FFFF, 32'h8000_0000, 0, ST_CLAMP_FIRST);
		add_row(CMD_QUERY, 0, 0, 0, 0, 32'h0003_0000,
			1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, ST_CLAMP_LAST);
		// exactly on the first key: factor zero
		add_row(CMD_QUERY, 0, 0, 0, 0, 32'h0001_0000,
			1, 32'h7FFF_FFFF, 32'h8000_0000, 0, ST_INTERP);
		add_row(CMD_QUERY, 0, 0, 0, 0, 32'h0002_0000, 0, 0, 0, 0, ST_INTERP);
		// largest factor, full-scale deltas
		add_row(CMD_QUERY, 0, 0, 0, 0, 32'h0002_FFFF, 0, 0, 0, 0, ST_INTERP);
		add_row(CMD_APPEND, 32'hFFFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 1, 0, 0, 0, ST_LOADED);
		add_row(CMD_QUERY, 0, 0, 0, 0, 32'hFFFF_FFFE, 0, 0, 0, 0, ST_INTERP);
		add_row(CMD_QUERY, 0, 0, 0, 0, 32'hFFFF_FFFF,
			1, 0, 0, 32'h7FFF_FFFF, ST_CLAMP_LAST);
		add_row(CMD_QUERY_ALT, 0, 0, 0, 0, 32'h0001_8000, 0, 0, 0, 0, ST_INTERP);
		// key out of order
		add_row(CMD_APPEND, 32'h0000_0010, 32'h1234_5678, 32'hEDCB_A988, 32'h0001_0000, 0,
			1, 0, 0, 0, ST_LOADED);
		add_row(CMD_QUERY, 0, 0, 0, 0, 32'h0000_0020, 0, 0, 0, 0, ST_INTERP);
		add_row(CMD_QUERY, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, ST_INTERP);
		add_row(CMD_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0, 0, ST_CLEARED);
		add_row(CMD_QUERY, 0, 0, 0, 0, 32'h1234_5678, 1, 0, 0, 0, ST_EMPTY);
		// keys one tick apart
		add_row(CMD_APPEND, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 0,
			1, 0, 0, 0, ST_LOADED);
		add_row(CMD_APPEND, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
			1, 0, 0, 0, ST_LOADED);
		add_row(CMD_QUERY, 0, 0, 0, 0, 32'h0,
			1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, ST_INTERP);
		add_row(CMD_QUERY, 0, 0, 0, 0, 32'h1,
			1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ST_CLAMP_LAST);
		add_row(CMD_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0, 0, ST_CLEARED);

		foreach (dir_rows[i])
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
		wait_drained();

		// random: mostly clear, a key set, then queries; some loose items
		rand_start = items_sent;
		seq = 0;
		while (items_sent - rand_start < RAND_ITEMS) begin
			if (seq % 8 == 7)
				wait_drained();
			if (seq == 2 || seq == 12 || $urandom_range(0, 6) != 0) begin
				case ($urandom_range(0, 9))
					0:       n_keys = $urandom_range(0, 1);
					1:       n_keys = $urandom_range(9, 30);
					default: n_keys = $urandom_range(2, 8);
				endcase
				if (seq == 2 || seq == 12)
					n_keys = KEY_DEPTH + 2;	// fill up and overflow
				it = '{CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom};
				send_item(it, 0, none);
				case ($urandom_range(0, 2))
					0:       step_max = 32'h100;
					1:       step_max = 32'h4_0000;
					default: step_max = 32'hFFFF_FFFF / (n_keys + 1);
				endcase
				t = $urandom_range(0, 32'hFFFF_FFFF - step_max * (n_keys + 1));
				for (int k = 0; k < n_keys; k++) begin
					t += $urandom_range(1, step_max);
					it.cmd = CMD_APPEND;
					it.ktime = ($urandom_range(0, 9) == 0) ? $urandom : t;
					it.kx = pick_comp();
					it.ky = pick_comp();
					it.kz = pick_comp();
					it.qtime = $urandom;
					send_item(it, 0, none);
				end
				n_q = $urandom_range(2, 10);
				for (int q = 0; q < n_q; q++) begin
					it.cmd = ($urandom_range(0, 7) == 0) ? CMD_QUERY_ALT : CMD_QUERY;
					it.ktime = $urandom;
					it.kx = $urandom;
					it.ky = $urandom;
					it.kz = $urandom;
					it.qtime = pick_query_time();
					send_item(it, 0, none);
				end
			end else begin
				repeat ($urandom_range(1, 6)) begin
					it = '{2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
						$urandom, $urandom};
					if (it.cmd[CMD_QUERY_BIT] && $urandom_range(0, 1))
						it.qtime = pick_query_time();
					send_item(it, 0, none);
				end
			end
			seq++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d items sent, %0d results checked, %0d mismatches",
			items_sent, results_checked, err_count);
		$display("Statuses: interp %0d single %0d clamp-first %0d clamp-last %0d empty %0d loaded %0d full %0d cleared %0d",
			status_hits[ST_INTERP], status_hits[ST_SINGLE], status_hits[ST_CLAMP_FIRST],
			status_hits[ST_CLAMP_LAST], status_hits[ST_EMPTY], status_hits[ST_LOADED],
			status_hits[ST_FULL], status_hits[ST_CLEARED]);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
